// ----- rtl/rpwd_pkg.sv -----
// Package for the RF pulse-width decoder.
// Holds the counter width, register indexes, pulse kind codes and the shared structs.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package rpwd_pkg;

  // Width of the period and high-time counters
  localparam int unsigned CountWidth = 24;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Configuration port widths
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = CountWidth;
  localparam int unsigned FrameWidth    = 7;

  // Register indexes
  localparam logic [CfgIndexWidth-1:0] RegNoisePeriod = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegLongPeriod  = 8'd1;
  localparam logic [CfgIndexWidth-1:0] RegZeroPeriod  = 8'd2;
  localparam logic [CfgIndexWidth-1:0] RegFrameLimit  = 8'd3;

  // Register reset values
  localparam logic [CfgDataWidth-1:0] NoiseReset      = CfgDataWidth'(600);
  localparam logic [CfgDataWidth-1:0] LongReset       = CfgDataWidth'(2000);
  localparam logic [CfgDataWidth-1:0] ZeroReset       = CfgDataWidth'(1000);
  localparam logic [FrameWidth-1:0]   FrameLimitReset = 7'd72;

  // Pulse kind codes
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_ONE   = 2'd3
  } kind_e;

  // Configuration register set
  typedef struct packed {
    logic [CountWidth-1:0] noise_period;
    logic [CountWidth-1:0] long_period;
    logic [CountWidth-1:0] zero_period;
    logic [FrameWidth-1:0] frame_limit;
  } cfg_t;

  // Finished pulse from the timer
  typedef struct packed {
    logic                  valid;
    logic [CountWidth-1:0] period;
    logic [CountWidth-1:0] duty;
  } pulse_t;

  // Decoded result
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic       byte_valid;
    logic [7:0] byte_value;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/rf_pulse_width_decoder_unit.sv -----
// Top level of the RF pulse-width decoder.
// Depends on rpwd_pkg, rpwd_cfg_regs, rpwd_timer and rpwd_classifier.
//
// The decoder takes one sampled receiver level per request and can take a new
// request in every cycle. Each sample is held in an input register, then timed
// and classified combinationally, and the result, if any, lands in an output
// register. Only a stalled output register holds up the input side, and even
// then one more sample is buffered. Most samples produce no result; a result
// is produced at a rising edge that ends a pulse which is not noise, unless it
// is a data bit past the frame limit, and carries a start, stop, zero or one
// kind plus a completed byte every eighth bit. Registers reset to noise 600,
// long 2000, zero 1000 and a frame limit of 72 bits.
`default_nettype none

module rf_pulse_width_decoder_unit
  import rpwd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     line_level_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [1:0]                    pulse_kind_o,
  output logic                          byte_valid_o,
  output logic [7:0]                    byte_value_o
);

  cfg_t    cfg;
  pulse_t  pulse;
  result_t result;

  logic       in_valid_q, in_valid_d;
  logic       level_q;
  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q;
  logic       bvalid_q;
  logic [7:0] bvalue_q;
  logic       advance;
  logic       in_take;

  // Move the held sample on when the output register is free or draining
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  rpwd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rpwd_timer u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (level_q),
    .pulse_o (pulse)
  );

  rpwd_classifier u_class (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .pulse_i  (pulse),
    .result_o (result)
  );

  // Input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = result.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      level_q <= line_level_i;
    end
    if (advance && result.valid) begin
      kind_q   <= result.kind;
      bvalid_q <= result.byte_valid;
      bvalue_q <= result.byte_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pulse_kind_o = kind_q;
  assign byte_valid_o = bvalid_q;
  assign byte_value_o = bvalue_q;

endmodule

`default_nettype wire

// ----- rtl/rpwd_cfg_regs.sv -----
// Configuration registers of the RF pulse-width decoder.
// Depends on rpwd_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module rpwd_cfg_regs
  import rpwd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i,
  output cfg_t                          cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; ignore indexes beyond the list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegNoisePeriod: cfg_d.noise_period = cfg_data_i[CountWidth-1:0];
        RegLongPeriod:  cfg_d.long_period  = cfg_data_i[CountWidth-1:0];
        RegZeroPeriod:  cfg_d.zero_period  = cfg_data_i[CountWidth-1:0];
        RegFrameLimit:  cfg_d.frame_limit  = cfg_data_i[FrameWidth-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_period <= NoiseReset[CountWidth-1:0];
      cfg_q.long_period  <= LongReset[CountWidth-1:0];
      cfg_q.zero_period  <= ZeroReset[CountWidth-1:0];
      cfg_q.frame_limit  <= FrameLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/rpwd_timer.sv -----
// Pulse timer: tracks edges and times period and high time of each pulse.
// Depends on rpwd_pkg for CountWidth, CountMax and pulse_t.
`default_nettype none

module rpwd_timer
  import rpwd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic level_i,
  output pulse_t    pulse_o
);

  logic                  synced_q, synced_d;
  logic                  prev_q, prev_d;
  logic                  low_q, low_d;
  logic [CountWidth-1:0] high_q, high_d;
  logic [CountWidth-1:0] len_q, len_d;
  logic                  rising, falling;
  logic [CountWidth-1:0] len_inc, high_inc;

  assign rising   = level_i & ~prev_q;
  assign falling  = ~level_i & prev_q;
  assign len_inc  = (len_q == CountMax) ? CountMax : len_q + 1'b1;
  assign high_inc = (high_q == CountMax) ? CountMax : high_q + 1'b1;

  // Report a finished pulse on each rising edge once synced
  assign pulse_o.valid  = step_i & synced_q & rising;
  assign pulse_o.period = len_inc;
  assign pulse_o.duty   = high_q;

  // Restart on a rising edge, otherwise advance the counters
  always_comb begin
    synced_d = synced_q;
    prev_d   = prev_q;
    low_d    = low_q;
    high_d   = high_q;
    len_d    = len_q;
    if (step_i) begin
      prev_d = level_i;
      if (rising) begin
        synced_d = 1'b1;
        low_d    = 1'b0;
        high_d   = '0;
        len_d    = '0;
      end else if (synced_q) begin
        len_d = len_inc;
        if (!low_q) begin
          high_d = high_inc;
          if (falling) begin
            low_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q <= 1'b0;
      prev_q   <= 1'b0;
      low_q    <= 1'b0;
      high_q   <= '0;
      len_q    <= '0;
    end else begin
      synced_q <= synced_d;
      prev_q   <= prev_d;
      low_q    <= low_d;
      high_q   <= high_d;
      len_q    <= len_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpwd_classifier.sv -----
// Pulse classifier: sorts finished pulses and assembles bits into bytes.
// Depends on rpwd_pkg for cfg_t, pulse_t, result_t and the kind codes.
`default_nettype none

module rpwd_classifier
  import rpwd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  pulse_t    pulse_i,
  output result_t   result_o
);

  logic [7:0]            shift_q, shift_d;
  logic [2:0]            bcnt_q, bcnt_d;
  logic [FrameWidth-1:0] fcnt_q, fcnt_d;
  logic                  is_noise, is_long, is_zero, frame_full, wide_high;
  logic [7:0]            shift_next;

  assign is_noise   = pulse_i.period <= cfg_i.noise_period;
  assign is_long    = pulse_i.period > cfg_i.long_period;
  assign is_zero    = pulse_i.period > cfg_i.zero_period;
  assign wide_high  = pulse_i.duty > (pulse_i.period >> 2);
  assign frame_full = fcnt_q >= cfg_i.frame_limit;
  assign shift_next = {shift_q[6:0], ~is_zero};

  // Classify and update the byte and frame counts
  always_comb begin
    shift_d             = shift_q;
    bcnt_d              = bcnt_q;
    fcnt_d              = fcnt_q;
    result_o.valid      = 1'b0;
    result_o.kind       = KIND_START;
    result_o.byte_valid = 1'b0;
    result_o.byte_value = '0;
    if (pulse_i.valid && !is_noise) begin
      if (is_long) begin
        result_o.valid = 1'b1;
        result_o.kind  = wide_high ? KIND_START : KIND_STOP;
        bcnt_d         = '0;
        fcnt_d         = '0;
      end else if (!frame_full) begin
        result_o.valid = 1'b1;
        result_o.kind  = is_zero ? KIND_ZERO : KIND_ONE;
        fcnt_d         = fcnt_q + 1'b1;
        if (bcnt_q == 3'd7) begin
          result_o.byte_valid = 1'b1;
          result_o.byte_value = shift_next;
          shift_d             = '0;
          bcnt_d              = '0;
        end else begin
          shift_d = shift_next;
          bcnt_d  = bcnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bcnt_q  <= '0;
      fcnt_q  <= '0;
    end else begin
      shift_q <= shift_d;
      bcnt_q  <= bcnt_d;
      fcnt_q  <= fcnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpwd_checker.sv -----
// Port-level checks for the RF pulse-width decoder, bound to the top level.
// Depends on rpwd_pkg for the kind codes and on rf_pulse_width_decoder_unit.
`default_nettype none

module rpwd_checker
  import rpwd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] pulse_kind_o,
  input wire logic       byte_valid_o,
  input wire logic [7:0] byte_value_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_kind_o)
      && $stable(byte_valid_o) && $stable(byte_value_o))
    else $error("stalled result changed");

  // Only data bits complete a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> pulse_kind_o == KIND_ZERO || pulse_kind_o == KIND_ONE)
    else $error("byte completed by start or stop");

  // No byte value without a completed byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> byte_value_o == 8'd0)
    else $error("byte value without completed byte");

  // A draining output never blocks a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

endmodule

bind rf_pulse_width_decoder_unit rpwd_checker u_rpwd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pulse_kind_o (pulse_kind_o),
  .byte_valid_o (byte_valid_o),
  .byte_value_o (byte_value_o)
);

`default_nettype wire

// ----- sim/rf_pulse_width_decoder_unit_test.sv -----
// Self-checking testbench for rf_pulse_width_decoder_unit.
// Drives line samples as pulse trains through the request handshake, predicts
// each decoded pulse in step, and depends only on rpwd_pkg and the RTL.
module rf_pulse_width_decoder_unit_test;
  import rpwd_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic       byte_valid;
    logic [7:0] byte_value;
  } decoded_t;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_START,
    SHAPE_STOP,
    SHAPE_ZERO,
    SHAPE_ONE
  } shape_e;

  localparam int ClkHigh        = 6;
  localparam int ClkLow         = 6;
  localparam int DrainCycles    = 6;
  localparam int MinSamples     = 1000;
  localparam int MinResults     = 60;
  localparam int SpanCap        = 24;
  localparam int MaxDrawnPeriod = 200;
  localparam logic [CfgDataWidth-1:0] AllOnes = {CfgDataWidth{1'b1}};

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index_i  = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i   = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     line_level_i = 1'b0;
  logic                     out_ready_i  = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic [1:0]               pulse_kind_o;
  logic                     byte_valid_o;
  logic [7:0]               byte_value_o;

  rf_pulse_width_decoder_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .line_level_i (line_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pulse_kind_o (pulse_kind_o),
    .byte_valid_o (byte_valid_o),
    .byte_value_o (byte_value_o)
  );

  always begin
    clk_i = 1'b1;
    #ClkHigh;
    clk_i = 1'b0;
    #ClkLow;
  end

  // Thresholds as the decoder sees them
  logic [CountWidth-1:0] noise_lim = NoiseReset;
  logic [CountWidth-1:0] long_lim  = LongReset;
  logic [CountWidth-1:0] zero_lim  = ZeroReset;
  logic [FrameWidth-1:0] frame_lim = FrameLimitReset;

  // Pulse timing and bit assembly state
  logic                  synced     = 1'b0;
  logic                  prev_level = 1'b0;
  logic                  low_phase  = 1'b0;
  logic [CountWidth-1:0] high_cnt   = '0;
  logic [CountWidth-1:0] period_cnt = '0;
  logic [7:0]            shift_reg  = '0;
  int                    byte_cnt   = 0;
  logic [FrameWidth-1:0] frame_cnt  = '0;

  logic     line_samples[$];
  decoded_t pending_results[$];

  logic taken      = 1'b0;
  int   gap_left   = 0;
  int   burst_left = 0;
  int   stall_tick = 0;

  int failures      = 0;
  int sent_samples  = 0;
  int results_seen  = 0;
  int bytes_seen    = 0;
  int settings_done = 0;

  function automatic logic [CountWidth-1:0] count_up(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Advance the decoder state by one sample and queue the pulse it completes
  task automatic decode_sample(input logic level);
    logic                  rising;
    logic                  falling;
    logic [CountWidth-1:0] period;
    decoded_t              res;
    rising     = level && !prev_level;
    falling    = !level && prev_level;
    prev_level = level;
    if (!synced) begin
      if (rising) begin
        synced     = 1'b1;
        period_cnt = '0;
        high_cnt   = '0;
        low_phase  = 1'b0;
      end
    end else if (rising) begin
      period = count_up(period_cnt);
      res.byte_valid = 1'b0;
      res.byte_value = '0;
      if (period > noise_lim) begin
        if (period > long_lim) begin
          // start or stop marker: duty decides, counts clear
          res.kind  = (high_cnt > (period >> 2)) ? KIND_START : KIND_STOP;
          byte_cnt  = 0;
          frame_cnt = '0;
          pending_results.push_back(res);
        end else if (frame_cnt < frame_lim) begin
          res.kind  = (period > zero_lim) ? KIND_ZERO : KIND_ONE;
          shift_reg = {shift_reg[6:0], res.kind == KIND_ONE};
          byte_cnt++;
          if (byte_cnt == 8) begin
            res.byte_valid = 1'b1;
            res.byte_value = shift_reg;
            byte_cnt       = 0;
            shift_reg      = '0;
          end
          frame_cnt = frame_cnt + 1'b1;
          pending_results.push_back(res);
        end
      end
      period_cnt = '0;
      high_cnt   = '0;
      low_phase  = 1'b0;
    end else begin
      period_cnt = count_up(period_cnt);
      if (!low_phase) begin
        high_cnt = count_up(high_cnt);
        if (falling) begin
          low_phase = 1'b1;
        end
      end
    end
  endtask

  // Check delivered results, then predict from accepted requests
  always @(posedge clk_i) begin : monitor
    decoded_t want;
    taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: pulse_kind %0d byte_valid %0d byte_value %0d",
               pulse_kind_o, byte_valid_o, byte_value_o);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (pulse_kind_o !== want.kind) begin
          $error("pulse_kind: expected %0d, got %0d", want.kind, pulse_kind_o);
          failures++;
        end
        if (byte_valid_o !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid_o);
          failures++;
        end
        if (byte_value_o !== want.byte_value) begin
          $error("byte_value: expected %0d, got %0d", want.byte_value, byte_value_o);
          failures++;
        end
        results_seen++;
        if (want.byte_valid) begin
          bytes_seen++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      decode_sample(line_level_i);
      sent_samples++;
    end
  end

  // Send requests in bursts; stall the result side on a rotating pattern
  always @(negedge clk_i) begin
    if (!(in_valid_i && !taken)) begin
      if (gap_left > 0 || line_samples.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end
      end else begin
        in_valid_i   <= 1'b1;
        line_level_i <= line_samples.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom % 4 == 0) ? 0 : $urandom_range(6, 1);
        end
      end
    end
    stall_tick++;
    case ((stall_tick / 150) % 3)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom % 4 != 0);
      default: out_ready_i <= ((stall_tick % 16) < 5);
    endcase
  end

  // Hold off until every request and result has cleared the decoder
  task automatic drain();
    while (!(line_samples.size() == 0 && !in_valid_i && pending_results.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CfgIndexWidth-1:0] idx,
                              input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      RegNoisePeriod: noise_lim = data;
      RegLongPeriod:  long_lim  = data;
      RegZeroPeriod:  zero_lim  = data;
      RegFrameLimit:  frame_lim = data[FrameWidth-1:0];
      default: ;
    endcase
  endtask

  // Write all thresholds plus one stray index, then drop the write enable
  task automatic program_thresholds(input logic [CfgDataWidth-1:0] noise,
                                    input logic [CfgDataWidth-1:0] long_p,
                                    input logic [CfgDataWidth-1:0] zero,
                                    input logic [FrameWidth-1:0] limit);
    logic [CfgDataWidth-1:0] stray;
    stray = ($urandom % 2) ? AllOnes : CfgDataWidth'($urandom);
    set_register(CfgIndexWidth'($urandom_range(255, 4)), stray);
    set_register(RegNoisePeriod, noise);
    set_register(RegLongPeriod, long_p);
    set_register(RegZeroPeriod, zero);
    set_register(RegFrameLimit, {($urandom % 2) ? {(CfgDataWidth-FrameWidth){1'b1}}
                                 : (CfgDataWidth-FrameWidth)'($urandom), limit});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  task automatic push_pulse(input int high, input int low);
    repeat (high) line_samples.push_back(1'b1);
    repeat (low) line_samples.push_back(1'b0);
  endtask

  // Pick a period in range; zero when the range is empty or too long to send
  function automatic int draw_period(input int lo, input int hi);
    if (lo < 2) lo = 2;
    if (hi > lo + SpanCap) hi = lo + SpanCap;
    if (lo > MaxDrawnPeriod || hi < lo) return 0;
    return $urandom_range(hi, lo);
  endfunction

  task automatic push_shape(input shape_e shape);
    int p;
    int h;
    int lo_long;
    lo_long = ((noise_lim > long_lim) ? noise_lim : long_lim) + 1;
    case (shape)
      SHAPE_NOISE: p = draw_period(2, noise_lim);
      SHAPE_ONE:   p = draw_period(noise_lim + 1, (zero_lim < long_lim) ? zero_lim : long_lim);
      SHAPE_ZERO:  p = draw_period(((noise_lim > zero_lim) ? noise_lim : zero_lim) + 1, long_lim);
      default:     p = draw_period(lo_long, lo_long + SpanCap);
    endcase
    if (p == 0) p = $urandom_range(20, 2);
    case (shape)
      SHAPE_START: h = $urandom_range(p - 1, p / 4 + 1);
      SHAPE_STOP:  h = (p >= 4) ? $urandom_range(p / 4, 1) : 1;
      default:     h = $urandom_range(p - 1, 1);
    endcase
    push_pulse(h, p - h);
  endtask

  // Queue one frame of marker, bits and marker, or a burst of line junk
  task automatic push_frame();
    int nbits;
    if ($urandom_range(99, 0) < 15) begin
      repeat ($urandom_range(30, 5)) line_samples.push_back(1'($urandom));
    end else begin
      push_shape(SHAPE_START);
      nbits = ($urandom % 3 == 0) ? 8 * $urandom_range(3, 1) : $urandom_range(20, 0);
      repeat (nbits) begin
        if ($urandom % 10 == 0) push_shape(SHAPE_NOISE);
        push_shape(($urandom % 2) ? SHAPE_ZERO : SHAPE_ONE);
      end
      push_shape(($urandom % 4 == 0) ? SHAPE_START : SHAPE_STOP);
    end
  endtask

  task automatic run_phase();
    int                    mode;
    int                    frames;
    logic [CountWidth-1:0] noise;
    logic [CountWidth-1:0] zero;
    mode = $urandom_range(9, 0);
    if (mode <= 5) begin
      noise = CountWidth'($urandom_range(4, 0));
      zero  = noise + CountWidth'($urandom_range(8, 1));
      program_thresholds(noise, zero + CountWidth'($urandom_range(10, 1)), zero,
                         ($urandom % 3 == 0) ? FrameWidth'($urandom_range(12, 0))
                                             : FrameWidth'($urandom_range(127, 40)));
      frames = $urandom_range(8, 3);
    end else if (mode == 6) begin
      // every pulse above zero samples is a marker, every bit is dropped
      program_thresholds('0, '0, '0, '0);
      frames = 3;
    end else if (mode == 7) begin
      // everything falls under the noise bound
      program_thresholds(AllOnes, AllOnes, AllOnes, {FrameWidth{1'b1}});
      frames = 2;
    end else begin
      // no markers: bits pile up until the frame limit cuts them off
      noise = CountWidth'($urandom_range(2, 0));
      zero  = ($urandom % 2) ? noise + CountWidth'($urandom_range(6, 1)) : AllOnes;
      program_thresholds(noise, AllOnes, zero,
                         ($urandom % 2) ? {FrameWidth{1'b1}}
                                        : FrameWidth'($urandom_range(126, 60)));
      frames = 8;
    end
    repeat (frames) begin
      push_frame();
      if ($urandom % 6 == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: first sample high, noise, start, one, zero, bit past limit, stop
    program_thresholds(24'd2, 24'd4, 24'd3, 7'd2);
    line_samples.push_back(1'b1);
    line_samples.push_back(1'b0);
    push_pulse(3, 3);
    push_pulse(1, 2);
    push_pulse(2, 2);
    push_pulse(1, 2);
    push_pulse(1, 5);
    line_samples.push_back(1'b1);
    drain();

    while (sent_samples < MinSamples || results_seen < MinResults) begin
      run_phase();
    end

    drain();
    $display("Run covered %0d line samples under %0d threshold settings,", sent_samples,
             settings_done);
    $display("checking %0d decoded pulses of which %0d completed a byte.", results_seen,
             bytes_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
